// ===== design/charge_comparison_psd_assert.svh =====
// assertion macros shared by the pulse shape discrimination rtl
// no dependencies; included by the modules that carry assertions
`ifndef CHARGE_COMPARISON_PSD_ASSERT_SVH
`define CHARGE_COMPARISON_PSD_ASSERT_SVH

// implication checked at every rising edge outside reset
`define CCPSD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// plain invariant checked at every rising edge outside reset
`define CCPSD_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// ===== design/ccpsd_pkg.sv =====
// types, constants and helpers of the charge comparison psd block
// no dependencies; used by every module of the block
package ccpsd_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int ACC_W   = 28;
   localparam int PSD_W   = 18;
   localparam int PRE_W   = 12;
   localparam int TRIG_W  = 12;
   localparam int GATE_W  = 13;
   localparam int CSR_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int Q_BITS  = 17;
   localparam int QUEUE_DEPTH = 4;

   localparam int RSP_W = ((PSD_W + 2 * ACC_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PRETRIG    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GATE  = 2'd2;

   localparam logic [PRE_W-1:0]  PRETRIG_RST    = 12'd8;
   localparam logic [GATE_W-1:0] SHORT_GATE_RST = 13'd32;
   localparam logic [GATE_W-1:0] LONG_GATE_RST  = 13'd256;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 28'sh7FFFFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 28'sh8000000;
   localparam logic signed [PSD_W-1:0] PSD_MAX = 18'sh1FFFF;
   localparam logic signed [PSD_W-1:0] PSD_MIN = 18'sh20000;
   localparam logic signed [PSD_W-1:0] PSD_INVALID = 18'sh30000;

   typedef struct packed {
      logic signed [ACC_W-1:0] long_sum;
      logic signed [ACC_W-1:0] short_sum;
   } ccpsd_sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ccpsd_qstat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_CHECK,
      BK_DIV,
      BK_DONE
   } ccpsd_bk_state_type;

   // saturating add over the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] t;
      t = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (t[ACC_W] != t[ACC_W-1]) begin
         return t[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return t[ACC_W-1:0];
   endfunction

endpackage

// ===== design/ccpsd_front.sv =====
// front end: configuration registers, gate tracking and the two integrators
// depends on ccpsd_pkg; pushes finished sum pairs into ccpsd_queue
`include "charge_comparison_psd_assert.svh"

module ccpsd_front #(
   parameter int MAX_SAMPLES = ccpsd_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = ccpsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ccpsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccpsd_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample,
   input  logic [ccpsd_pkg::TRIG_W-1:0]      in_trigger,
   input  logic                              in_last,
   input  ccpsd_pkg::ccpsd_qstat_type        qstat,
   output logic                              push,
   output ccpsd_pkg::ccpsd_sums_type         push_data
);
   import ccpsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W = ((CNT_W > GATE_W) ? CNT_W : GATE_W) + 1;

   logic [PRE_W-1:0]  pretrig_ff, pretrig_in;
   logic [GATE_W-1:0] short_gate_ff, short_gate_in;
   logic [GATE_W-1:0] long_gate_ff, long_gate_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TRIG_W-1:0]       gate_start_ff, gate_start_in;
   logic signed [ACC_W-1:0] short_ff, short_in;
   logic signed [ACC_W-1:0] long_ff, long_in;

   logic                    accept;
   logic                    take;
   logic [TRIG_W-1:0]       gs_now;
   logic [CMP_W-1:0]        idx, lo;
   logic                    in_short, in_long;
   logic signed [ACC_W-1:0] x_ext;
   logic signed [ACC_W-1:0] short_nx, long_nx;

   assign in_ready = !qstat.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      pretrig_in    = pretrig_ff;
      short_gate_in = short_gate_ff;
      long_gate_in  = long_gate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRETRIG:    pretrig_in    = csr_wdata[PRE_W-1:0];
            CSR_SHORT_GATE: short_gate_in = csr_wdata[GATE_W-1:0];
            CSR_LONG_GATE:  long_gate_in  = csr_wdata[GATE_W-1:0];
            default: ;
         endcase
      end
   end

   // gate start is latched on the first sample of a waveform
   always_comb begin
      if (count_ff == '0) begin
         gs_now = (in_trigger > pretrig_ff) ? (in_trigger - pretrig_ff) : '0;
      end else begin
         gs_now = gate_start_ff;
      end
      take     = count_ff < CNT_W'(MAX_SAMPLES);
      idx      = CMP_W'(count_ff);
      lo       = CMP_W'(gs_now);
      in_short = take && (idx >= lo) && (idx < lo + CMP_W'(short_gate_ff));
      in_long  = take && (idx >= lo) && (idx < lo + CMP_W'(long_gate_ff));
      x_ext    = {{(ACC_W - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
      short_nx = in_short ? sat_add(short_ff, x_ext) : short_ff;
      long_nx  = in_long  ? sat_add(long_ff, x_ext)  : long_ff;
   end

   always_comb begin
      count_in      = count_ff;
      gate_start_in = gate_start_ff;
      short_in      = short_ff;
      long_in       = long_ff;
      if (accept) begin
         if (in_last) begin
            count_in      = '0;
            gate_start_in = '0;
            short_in      = '0;
            long_in       = '0;
         end else begin
            count_in      = take ? count_ff + CNT_W'(1) : count_ff;
            gate_start_in = gs_now;
            short_in      = short_nx;
            long_in       = long_nx;
         end
      end
   end

   assign push                = accept && in_last;
   assign push_data.short_sum = short_nx;
   assign push_data.long_sum  = long_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         pretrig_ff    <= PRETRIG_RST;
         short_gate_ff <= SHORT_GATE_RST;
         long_gate_ff  <= LONG_GATE_RST;
         count_ff      <= '0;
         gate_start_ff <= '0;
         short_ff      <= '0;
         long_ff       <= '0;
      end else begin
         pretrig_ff    <= pretrig_in;
         short_gate_ff <= short_gate_in;
         long_gate_ff  <= long_gate_in;
         count_ff      <= count_in;
         gate_start_ff <= gate_start_in;
         short_ff      <= short_in;
         long_ff       <= long_in;
      end
   end

   `CCPSD_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= CNT_W'(MAX_SAMPLES), "sample count ran past its saturation point")

endmodule

// ===== design/ccpsd_queue.sv =====
// short register queue of finished sum pairs between front and back end
// depends on ccpsd_pkg
`include "charge_comparison_psd_assert.svh"

module ccpsd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ccpsd_pkg::ccpsd_sums_type   push_data,
   input  logic                        pop,
   output ccpsd_pkg::ccpsd_sums_type   pop_data,
   output ccpsd_pkg::ccpsd_qstat_type  qstat
);
   import ccpsd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   ccpsd_sums_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign qstat.full  = fill_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign qstat.empty = fill_ff == '0;
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   `CCPSD_ASSERT_IMP(a_no_overflow, clock, reset, push, !qstat.full,
      "sum pair pushed into a full queue")

endmodule

// ===== design/ccpsd_back.sv =====
// back end: restoring divider for 1 - short/long and the result register
// depends on ccpsd_pkg; pops sum pairs from ccpsd_queue
`include "charge_comparison_psd_assert.svh"

module ccpsd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ccpsd_pkg::ccpsd_qstat_type          qstat,
   input  ccpsd_pkg::ccpsd_sums_type           pop_data,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [ccpsd_pkg::PSD_W-1:0]  out_psd,
   output logic                                out_valid_res,
   output logic signed [ccpsd_pkg::ACC_W-1:0]  out_short,
   output logic signed [ccpsd_pkg::ACC_W-1:0]  out_long
);
   import ccpsd_pkg::*;

   localparam int ITER_W = $clog2(Q_BITS);

   ccpsd_bk_state_type state_ff, state_in;

   logic signed [ACC_W-1:0] s_ff, l_ff;
   logic [ACC_W-1:0]        diff_ff;
   logic [ACC_W-1:0]        d_ff;
   logic                    valid_ff, neg_ff, ovf_ff;
   logic [ACC_W:0]          rem_ff;
   logic [Q_BITS-1:0]       q_ff;
   logic [ITER_W-1:0]       iter_ff;

   logic                    out_valid_ff;
   logic signed [PSD_W-1:0] psd_ff;
   logic                    valid_res_ff;
   logic signed [ACC_W-1:0] short_out_ff, long_out_ff;

   logic                    out_free, load_out;
   logic [ACC_W:0]          diff_full;
   logic                    ge;
   logic [ACC_W:0]          rem_sub, rem_kept;
   logic signed [PSD_W-1:0] psd_calc;
   logic signed [PSD_W-1:0] q_ext;

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!qstat.empty) state_in = BK_LOAD;
         BK_LOAD:  state_in = BK_CHECK;
         BK_CHECK: state_in = BK_DIV;
         BK_DIV:   if (iter_ff == '0) state_in = BK_DONE;
         BK_DONE:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = !qstat.empty;
         BK_DONE: load_out = out_free;
         default: ;
      endcase
   end

   // one quotient bit per cycle; remainder stays below twice the divisor
   always_comb begin
      diff_full = {l_ff[ACC_W-1], l_ff} - {s_ff[ACC_W-1], s_ff};
      ge        = rem_ff >= {1'b0, d_ff};
      rem_sub   = rem_ff - {1'b0, d_ff};
      rem_kept  = ge ? rem_sub : rem_ff;
      q_ext     = $signed({1'b0, q_ff});
      if (!valid_ff) begin
         psd_calc = PSD_INVALID;
      end else if (ovf_ff) begin
         psd_calc = neg_ff ? PSD_MIN : PSD_MAX;
      end else begin
         psd_calc = neg_ff ? -q_ext : q_ext;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            s_ff <= pop_data.short_sum;
            l_ff <= pop_data.long_sum;
         end
         BK_LOAD: begin
            valid_ff <= l_ff > s_ff;
            neg_ff   <= l_ff[ACC_W-1];
            diff_ff  <= diff_full[ACC_W-1:0];
            d_ff     <= l_ff[ACC_W-1] ? ACC_W'(-l_ff) : ACC_W'(l_ff);
         end
         BK_CHECK: begin
            ovf_ff  <= {1'b0, diff_ff} >= {d_ff, 1'b0};
            rem_ff  <= {1'b0, diff_ff};
            iter_ff <= ITER_W'(Q_BITS - 1);
         end
         BK_DIV: begin
            rem_ff  <= {rem_kept[ACC_W-1:0], 1'b0};
            q_ff    <= {q_ff[Q_BITS-2:0], ge};
            iter_ff <= iter_ff - ITER_W'(1);
         end
         default: ;
      endcase
      if (load_out) begin
         psd_ff       <= psd_calc;
         valid_res_ff <= valid_ff;
         short_out_ff <= s_ff;
         long_out_ff  <= l_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_psd       = psd_ff;
   assign out_valid_res = valid_res_ff;
   assign out_short     = short_out_ff;
   assign out_long      = long_out_ff;

   `CCPSD_ASSERT_IMP(a_rem_bound, clock, reset,
      (state_ff == BK_DIV) && valid_ff && !ovf_ff, (rem_ff < {d_ff, 1'b0}),
      "divider remainder escaped its bound")
   `CCPSD_ASSERT_IMP(a_invalid_code, clock, reset,
      out_valid_ff && !valid_res_ff, psd_ff == PSD_INVALID,
      "invalid result carries a psd value other than minus one")

endmodule

// ===== design/charge_comparison_psd.sv =====
// top level of charge comparison pulse shape discrimination
// depends on ccpsd_pkg, ccpsd_front, ccpsd_queue and ccpsd_back
//
//  port group | dir | fields
//  req_*      | in  | tdata: sample, trigger_index; tlast: last
//  rsp_*      | out | tdata: psd_value, short_sum, long_sum; tuser: valid_res
//  csr_*      | in  | 0 pretrigger length, 1 short_gate, 2 long_gate
//
// one sample is taken per cycle while req_tready is high; the integrators add in
// the cycle of the transfer; a result passes queue pop, the set-up states
// BK_LOAD and BK_CHECK, the one-bit-per-cycle divider and the output register load
// the divider serves one waveform at a time; a 4-entry queue of sum pairs lets
// further waveforms follow; req_tready drops only while the queue is full
// synchronous active-high reset; no clearing pass, the block is ready after reset
module charge_comparison_psd #(
   parameter int MAX_SAMPLES = ccpsd_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = ccpsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  csr_we,
   input  logic [ccpsd_pkg::CSR_IDX_W-1:0]                       csr_index,
   input  logic [ccpsd_pkg::CSR_W-1:0]                           csr_wdata,
   input  logic                                                  req_tvalid,
   output logic                                                  req_tready,
   // sample, trigger_index, zero fill
   input  logic [((SAMPLE_BITS + ccpsd_pkg::TRIG_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                                  req_tlast,
   output logic                                                  rsp_tvalid,
   input  logic                                                  rsp_tready,
   // psd_value, short_sum, long_sum, zero fill
   output logic [ccpsd_pkg::RSP_W-1:0]                           rsp_tdata,
   // valid_res
   output logic                                                  rsp_tuser
);
   import ccpsd_pkg::*;

   localparam int PAD_W = RSP_W - PSD_W - 2 * ACC_W;

   ccpsd_qstat_type         qstat;
   ccpsd_sums_type          push_data, pop_data;
   logic                    push, pop;
   logic signed [PSD_W-1:0] psd;
   logic                    valid_res;
   logic signed [ACC_W-1:0] short_sum, long_sum;

   ccpsd_front #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .in_trigger(req_tdata[SAMPLE_BITS + TRIG_W - 1:SAMPLE_BITS]),
      .in_last   (req_tlast),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   ccpsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .qstat    (qstat)
   );

   ccpsd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .pop_data     (pop_data),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_psd      (psd),
      .out_valid_res(valid_res),
      .out_short    (short_sum),
      .out_long     (long_sum)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, long_sum, short_sum, psd};
   assign rsp_tuser = valid_res;

endmodule
